### src/ymf_pkg.sv
// Shared types, constants and color conversion functions for the YCbCr median filter.
package ymf_pkg;

    localparam int unsigned PixW = 24;

    typedef logic [PixW-1:0] ycc_t;

    // flags that travel with a window shift into the output stage
    typedef struct packed {
        logic emit;
        logic top_out;
        logic bot_out;
        logic left_out;
        logic right_out;
        logic last;
    } pos_t;

    // forward conversion; all three sums are non-negative and below 2^24
    function automatic ycc_t to_ycc(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b);
        logic [25:0] y;
        logic [25:0] cb;
        logic [25:0] cr;
        y  = 26'd19589 * r + 26'd38443 * g + 26'd7504 * b;
        cb = 26'd8388608 + 26'd32768 * b - 26'd11056 * r - 26'd21712 * g;
        cr = 26'd8388608 + 26'd32768 * r - 26'd27420 * g - 26'd5348 * b;
        return {y[23:16], cb[23:16], cr[23:16]};
    endfunction

    function automatic logic [7:0] max8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    // Q.16 product truncated toward zero
    function automatic logic signed [9:0] trunc_q16(input logic signed [26:0] v);
        logic [26:0] mag;
        logic [26:0] sh;
        mag = v[26] ? 27'(-v) : 27'(v);
        sh  = mag >> 16;
        return v[26] ? 10'(-$signed({1'b0, sh[9:0]})) : $signed(sh[9:0]);
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [11:0] v);
        if (v < 0) begin
            return 8'd0;
        end else if (v > 12'sd255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

endpackage

### src/ymf_line_store.sv
// Two-row line store in one synchronous memory; a column is read on its beat and written back the cycle after.
module ymf_line_store #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  col,
    input  ymf_pkg::ycc_t                 cur,
    output ymf_pkg::ycc_t                 row0,
    output ymf_pkg::ycc_t                 row1
);
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // one word holds both rows of a column: {upper, lower}
    logic [2*ymf_pkg::PixW-1:0] mem [MAX_WIDTH];
    logic [2*ymf_pkg::PixW-1:0] rd_reg;
    logic [2*ymf_pkg::PixW-1:0] wr_word;
    logic [AW-1:0]              addr;
    logic [AW-1:0]              wr_addr_reg;
    ymf_pkg::ycc_t              wr_cur_reg;
    logic                       wr_pend_reg;

    assign addr = AW'(col);

    // previous beat's column: old lower row moves up, new pixel goes below
    assign wr_word = {rd_reg[ymf_pkg::PixW-1:0], wr_cur_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pend_reg <= 1'b0;
        end else begin
            wr_pend_reg <= en;
        end
    end

    // write-back comes in the cycle after the read; same column back to back is forwarded
    always_ff @(posedge aclk) begin
        if (wr_pend_reg) begin
            mem[wr_addr_reg] <= wr_word;
        end
        if (en) begin
            rd_reg      <= (wr_pend_reg && wr_addr_reg == addr) ? wr_word : mem[addr];
            wr_addr_reg <= addr;
            wr_cur_reg  <= cur;
        end
    end

    assign row0 = rd_reg[2*ymf_pkg::PixW-1:ymf_pkg::PixW];
    assign row1 = rd_reg[ymf_pkg::PixW-1:0];
endmodule

### src/ymf_median.sv
// Median of nine 8-bit values through a fixed compare network, two register stages.
module ymf_median (
    input  logic        aclk,
    input  logic        en,
    input  logic [7:0]  v [9],
    output logic [7:0]  med
);
    logic [7:0] lo_reg [3];
    logic [7:0] mi_reg [3];
    logic [7:0] hi_reg [3];
    logic [7:0] lo_next [3];
    logic [7:0] mi_next [3];
    logic [7:0] hi_next [3];
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] t;
    logic [7:0] med_next;
    logic [7:0] med_reg;

    // sort each triple
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t          = ymf_pkg::min8(v[3*i], v[3*i+1]);
            hi_next[i] = ymf_pkg::max8(ymf_pkg::max8(v[3*i], v[3*i+1]), v[3*i+2]);
            lo_next[i] = ymf_pkg::min8(t, v[3*i+2]);
            mi_next[i] = ymf_pkg::max8(t, ymf_pkg::min8(
                         ymf_pkg::max8(v[3*i], v[3*i+1]), v[3*i+2]));
        end
    end

    // median = med(max of lows, med of mids, min of highs)
    always_comb begin
        a        = ymf_pkg::max8(ymf_pkg::max8(lo_reg[0], lo_reg[1]), lo_reg[2]);
        c        = ymf_pkg::min8(ymf_pkg::min8(hi_reg[0], hi_reg[1]), hi_reg[2]);
        b        = ymf_pkg::max8(ymf_pkg::min8(mi_reg[0], mi_reg[1]),
                   ymf_pkg::min8(ymf_pkg::max8(mi_reg[0], mi_reg[1]), mi_reg[2]));
        med_next = ymf_pkg::max8(ymf_pkg::min8(a, b),
                   ymf_pkg::min8(ymf_pkg::max8(a, b), c));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg  <= lo_next;
            mi_reg  <= mi_next;
            hi_reg  <= hi_next;
            med_reg <= med_next;
        end
    end

    assign med = med_reg;
endmodule

### src/ycbcr_median_filter_3x3.sv
// Top level: YCbCr 3x3 median filter over an RGB raster pixel stream.
// One beat is taken per clock whenever the output stage can move; the memory read, window
// shift, neighbor masking, median network (two register stages) and color conversion form
// a six-stage pipeline. The only feedback is the line store, a single memory read and
// written at one column per beat. A result appears frame_width+1 beats after its input
// pixel; after the last pixel of a frame send frame_width+1 beats with s_axis_tuser set to
// flush. Register writes restart the frame; line store contents need no clearing since
// stale entries fall outside the frame and read as zero.
module ycbcr_median_filter_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
    output logic        m_axis_tlast,   // frame_end
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_wdata
);
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = $clog2(MAX_HEIGHT + 2) + 1;
    localparam int LAT = 5;

    localparam logic [10:0] REG_WIDTH_RESET  = 11'd512;
    localparam logic [12:0] REG_HEIGHT_RESET = 13'd512;
    localparam logic        IDX_WIDTH        = 1'b0;

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [13:0] w;
    logic [16:0] h;
    logic [13:0] in_col_reg;
    logic [RW-1:0] in_row_reg;
    logic [13:0] out_col_reg;
    logic [RW-1:0] out_row_reg;

    logic accept;
    logic step;
    logic flushing;
    logic emit;
    ymf_pkg::ycc_t cur;
    ymf_pkg::ycc_t row0;
    ymf_pkg::ycc_t row1;
    ymf_pkg::ycc_t cur_reg;

    logic [LAT-1:0] vld_reg;
    ymf_pkg::pos_t pos_reg [LAT];
    logic adv;

    logic [7:0] m_r_reg;
    logic [7:0] m_g_reg;
    logic [7:0] m_b_reg;
    logic       m_last_reg;
    logic       m_valid_reg;

    always_comb begin
        w = (width_reg == 11'd0) ? 14'd1
          : (14'(width_reg) > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : 14'(width_reg);
        h = (height_reg == 13'd0) ? 17'd1
          : (17'(height_reg) > 17'(MAX_HEIGHT)) ? 17'(MAX_HEIGHT) : 17'(height_reg);
    end

    // pipeline moves when the output slot is free or being drained
    assign adv           = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign flushing      = 17'(in_row_reg) >= h;
    assign step          = accept && (!s_axis_tuser || flushing);
    assign emit          = (17'(in_row_reg) >= 17'd2) ||
                           (in_row_reg == RW'(1) && in_col_reg >= 14'd1);
    assign cur = flushing ? '0
               : ymf_pkg::to_ycc(s_axis_tdata[7:0], s_axis_tdata[15:8],
                                 s_axis_tdata[23:16]);

    ymf_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_ls (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (step),
        .col     (CW'(in_col_reg)),
        .cur     (cur),
        .row0    (row0),
        .row1    (row1)
    );

    ymf_pkg::pos_t pos_next;
    logic          last_px;
    always_comb begin
        last_px            = (17'(out_row_reg) + 17'd1 >= h) && (out_col_reg + 14'd1 >= w);
        pos_next.emit      = emit;
        pos_next.top_out   = out_row_reg == '0;
        pos_next.bot_out   = 17'(out_row_reg) + 17'd1 >= h;
        pos_next.left_out  = out_col_reg == '0;
        pos_next.right_out = out_col_reg + 14'd1 >= w;
        pos_next.last      = last_px;
    end

    // counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= REG_WIDTH_RESET;
            height_reg  <= REG_HEIGHT_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == IDX_WIDTH) begin
                width_reg <= cfg_wdata[10:0];
            end else begin
                height_reg <= cfg_wdata;
            end
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (step) begin
            if (emit && last_px) begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end else begin
                if (in_col_reg + 14'd1 >= w) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + RW'(1);
                end else begin
                    in_col_reg <= in_col_reg + 14'd1;
                end
                if (emit) begin
                    if (out_col_reg + 14'd1 >= w) begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + RW'(1);
                    end else begin
                        out_col_reg <= out_col_reg + 14'd1;
                    end
                end
            end
        end
    end

    // stage 1: memory read; valid bits follow each emitting beat down the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], step && emit};
        end
    end

    // window and per-stage flags; the window shifts once the stepped beat's read data is registered
    logic           shift_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= 1'b0;
        end else if (adv) begin
            shift_reg <= step;
        end
    end

    ymf_pkg::ycc_t win_q [3][3];
    always_ff @(posedge aclk) begin
        if (adv) begin
            cur_reg <= cur;
            pos_reg[0] <= pos_next;
            for (int i = 1; i < LAT; i++) begin
                pos_reg[i] <= pos_reg[i-1];
            end
        end
    end

    // stage 2: window register bank, shifted when a stepped beat's read data is present
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_q[r][c] <= '0;
                end
            end
        end else if (adv && shift_reg) begin
            for (int r = 0; r < 3; r++) begin
                win_q[r][0] <= win_q[r][1];
                win_q[r][1] <= win_q[r][2];
            end
            win_q[0][2] <= row0;
            win_q[1][2] <= row1;
            win_q[2][2] <= cur_reg;
        end
    end

    // stage 3: mask outside neighbors (flags from pos_reg[1] align with win_q)
    logic [7:0] ch_reg [3][9];
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    for (int k = 0; k < 3; k++) begin
                        ch_reg[k][3*r+c] <=
                            ((r == 0 && pos_reg[1].top_out) ||
                             (r == 2 && pos_reg[1].bot_out) ||
                             (c == 0 && pos_reg[1].left_out) ||
                             (c == 2 && pos_reg[1].right_out))
                            ? 8'd0 : win_q[r][c][8*(2-k) +: 8];
                    end
                end
            end
        end
    end

    // stages 4-5: median network
    logic [7:0] med [3];
    for (genvar k = 0; k < 3; k++) begin : g_med
        ymf_median u_med (.aclk(aclk), .en(adv), .v(ch_reg[k]), .med(med[k]));
    end

    logic signed [8:0] db;
    logic signed [8:0] dr;
    logic signed [26:0] p_r;
    logic signed [26:0] p_g;
    logic signed [26:0] p_b;
    always_comb begin
        db  = $signed({1'b0, med[1]}) - 9'sd128;
        dr  = $signed({1'b0, med[2]}) - 9'sd128;
        p_r = 27'sd91881 * 27'(dr);
        p_g = 27'sd22553 * 27'(db) + 27'sd46802 * 27'(dr);
        p_b = 27'sd116130 * 27'(db);
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_r_reg    <= ymf_pkg::clamp8(12'($signed({1'b0, med[0]})) +
                                          12'(ymf_pkg::trunc_q16(p_r)));
            m_g_reg    <= ymf_pkg::clamp8(12'($signed({1'b0, med[0]})) -
                                          12'(ymf_pkg::trunc_q16(p_g)));
            m_b_reg    <= ymf_pkg::clamp8(12'($signed({1'b0, med[0]})) +
                                          12'(ymf_pkg::trunc_q16(p_b)));
            m_last_reg <= pos_reg[LAT-1].last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_b_reg, m_g_reg, m_r_reg};
    assign m_axis_tlast  = m_last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tready && m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while output stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && !flushing && s_axis_tuser |-> 1'b0)
        else $error("padding stepped inside frame");
endmodule

### sim/tb_ycbcr_median_filter_3x3.sv
// Testbench for the streaming YCbCr 3x3 median filter, with a built-in predictor and result checks.
`timescale 1ns / 100ps

module tb_ycbcr_median_filter_3x3;

    localparam int MaxW   = 1024;
    localparam int MaxH   = 4096;
    localparam int Settle = 40;

    typedef enum logic {OP_PIXEL = 1'b0, OP_PAD = 1'b1} op_e;
    typedef enum logic {REG_WIDTH = 1'b0, REG_HEIGHT = 1'b1} reg_e;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } pix_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // red_in, green_in, blue_in
    logic        s_axis_tuser = 1'b0; // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // red_out, green_out, blue_out
    logic        m_axis_tlast;        // frame_end
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [12:0] cfg_wdata = '0;

    ycbcr_median_filter_3x3 dut (.*);

    always #10 aclk = ~aclk;

    // predictor state
    logic [23:0] row_mem [2*MaxW];
    logic [23:0] win [3][3];
    int unsigned in_col, in_row, out_col, out_row;
    logic [10:0] width_reg = 11'd512;
    logic [12:0] height_reg = 13'd512;

    pix_out_t pending_pixels[$];
    int       errors = 0;
    int       beats_sent = 0;
    bit       tx_idle_en = 1'b1;
    bit       rx_idle_en = 1'b1;
    bit       hold_request = 1'b0;

    function automatic int unsigned eff_w();
        return (width_reg == 0) ? 1 : (width_reg > MaxW) ? MaxW : width_reg;
    endfunction

    function automatic int unsigned eff_h();
        return (height_reg == 0) ? 1 : (height_reg > MaxH) ? MaxH : height_reg;
    endfunction

    function automatic logic [23:0] rgb_to_ycc(int r, int g, int b);
        int y, cb, cr;
        y  = (19589 * r + 38443 * g + 7504 * b) >>> 16;
        cb = (8388608 + 32768 * b - 11056 * r - 21712 * g) >>> 16;
        cr = (8388608 + 32768 * r - 27420 * g - 5348 * b) >>> 16;
        if (y > 255) y = 255;
        if (cb > 255) cb = 255;
        if (cr > 255) cr = 255;
        return {y[7:0], cb[7:0], cr[7:0]};
    endfunction

    function automatic longint q16_toward_zero(longint v);
        return (v >= 0) ? (v >>> 16) : -((-v) >>> 16);
    endfunction

    function automatic logic [7:0] sat8(longint v);
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [7:0] median_of_nine(logic [7:0] v [9]);
        logic [7:0] s [9];
        logic [7:0] t;
        s = v;
        for (int i = 0; i < 9; i++) begin
            for (int j = 0; j < 8 - i; j++) begin
                if (s[j] > s[j+1]) begin
                    t = s[j];
                    s[j] = s[j+1];
                    s[j+1] = t;
                end
            end
        end
        return s[4];
    endfunction

    function automatic void clear_position();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    // advance the filter by one accepted beat; returns 1 when it yields a pixel
    function automatic bit filter_step(op_e op, logic [23:0] rgb, output pix_out_t px);
        int unsigned w, h, col;
        bit flushing, emit, outside;
        logic [23:0] cur;
        logic [23:0] nb [9];
        logic [7:0] chan [9];
        logic [7:0] med [3];
        longint yy, db, dr;
        w = eff_w();
        h = eff_h();
        px = '0;
        flushing = (in_row >= h);
        if (op == OP_PAD && !flushing) return 1'b0;
        cur = flushing ? 24'd0 : rgb_to_ycc(rgb[7:0], rgb[15:8], rgb[23:16]);
        col = (in_col >= MaxW) ? MaxW - 1 : in_col;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = row_mem[col];
        win[1][2] = row_mem[MaxW + col];
        win[2][2] = cur;
        row_mem[col] = row_mem[MaxW + col];
        row_mem[MaxW + col] = cur;
        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (!emit) return 1'b0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                outside = (r == 0 && out_row == 0) || (r == 2 && out_row + 1 >= h) ||
                          (c == 0 && out_col == 0) || (c == 2 && out_col + 1 >= w);
                nb[r*3+c] = outside ? 24'd0 : win[r][c];
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 9; k++) chan[k] = nb[k][16 - 8 * ch +: 8];
            med[ch] = median_of_nine(chan);
        end
        yy = med[0];
        db = longint'(med[1]) - 128;
        dr = longint'(med[2]) - 128;
        px.red       = sat8(yy + q16_toward_zero(91881 * dr));
        px.green     = sat8(yy - q16_toward_zero(22553 * db + 46802 * dr));
        px.blue      = sat8(yy + q16_toward_zero(116130 * db));
        px.frame_end = (out_row + 1 >= h) && (out_col + 1 >= w);
        if (px.frame_end) begin
            clear_position();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        return 1'b1;
    endfunction

    // one beat on the input side, predicted when accepted
    task automatic send_beat(op_e op, logic [23:0] rgb);
        pix_out_t px;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rgb;
        s_axis_tuser  <= op;
        do @(posedge aclk); while (!s_axis_tready);
        beats_sent++;
        if (filter_step(op, rgb, px)) pending_pixels.push_back(px);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        int n;
        n = 0;
        while (pending_pixels.size() != 0 && n < 400000) begin
            @(posedge aclk);
            n++;
        end
        repeat (Settle) @(posedge aclk);
    endtask

    task automatic write_reg(reg_e idx, logic [12:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_WIDTH) width_reg = value[10:0];
        else height_reg = value;
        clear_position();
        @(posedge aclk);
    endtask

    function automatic logic [23:0] rand_rgb();
        case ($urandom_range(0, 5))
            0: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, $urandom_range(0, 1) ? 8'hFF : 8'h00,
                       $urandom_range(0, 1) ? 8'hFF : 8'h00};
            default: return 24'($urandom());
        endcase
    endfunction

    // full frame plus flush; noise puts padding inside the frame and colored beats in the flush
    task automatic run_frame(bit noise);
        int unsigned w, h;
        w = eff_w();
        h = eff_h();
        for (int i = 0; i < w * h; i++) begin
            if (noise && $urandom_range(0, 15) == 0) send_beat(OP_PAD, 24'($urandom()));
            send_beat(OP_PIXEL, rand_rgb());
        end
        for (int i = 0; i <= w; i++) begin
            send_beat((noise && $urandom_range(0, 1)) ? OP_PIXEL : OP_PAD, 24'($urandom()));
        end
        stop_sending();
    endtask

    task automatic test_directed();
        logic [23:0] corners [6];
        corners = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000, 24'h7F8081};
        // zero registers clamp to a single-pixel frame
        write_reg(REG_WIDTH, 13'd0);
        write_reg(REG_HEIGHT, 13'd0);
        send_beat(OP_PAD, 24'hFFFFFF);
        send_beat(OP_PIXEL, 24'hFFFFFF);
        send_beat(OP_PIXEL, 24'h123456);
        send_beat(OP_PAD, 24'h0);
        stop_sending();
        write_reg(REG_WIDTH, 13'd3);
        write_reg(REG_HEIGHT, 13'd2);
        for (int i = 0; i < 6; i++) begin
            if (i == 3) send_beat(OP_PAD, 24'hABCDEF);
            send_beat(OP_PIXEL, corners[i]);
        end
        send_beat(OP_PIXEL, 24'hFFFFFF);
        send_beat(OP_PAD, 24'h0);
        send_beat(OP_PIXEL, 24'h000000);
        send_beat(OP_PAD, 24'h0);
        stop_sending();
    endtask

    task automatic test_backpressure();
        write_reg(REG_WIDTH, 13'd9);
        write_reg(REG_HEIGHT, 13'd6);
        hold_request = 1'b1;
        run_frame(1'b0);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int start;
        start = beats_sent;
        while (beats_sent - start < 760) begin
            if ($urandom_range(0, 1)) write_reg(REG_WIDTH, 13'($urandom_range(1, 12)));
            if ($urandom_range(0, 1)) write_reg(REG_HEIGHT, 13'($urandom_range(1, 8)));
            tx_idle_en = $urandom_range(0, 3) != 0;
            rx_idle_en = $urandom_range(0, 3) != 0;
            run_frame($urandom_range(0, 3) == 0);
        end
    endtask

    // oversize values clamp to the largest frame sizes (partial frames); no idling here
    task automatic test_extreme_sizes();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_reg(REG_WIDTH, 13'd2047);
        write_reg(REG_HEIGHT, 13'd1);
        for (int i = 0; i < 40; i++) begin
            send_beat(OP_PIXEL, rand_rgb());
        end
        stop_sending();
        write_reg(REG_WIDTH, 13'd1);
        write_reg(REG_HEIGHT, 13'd8191);
        for (int i = 0; i < 40; i++) begin
            send_beat(OP_PIXEL, rand_rgb());
        end
        stop_sending();
        write_reg(REG_WIDTH, 13'd4);
        write_reg(REG_HEIGHT, 13'd3);
        run_frame(1'b1);
    endtask

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        @(posedge aresetn);
        forever begin
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_request = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        pix_out_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected output beat %h last=%b",
                                           m_axis_tdata, m_axis_tlast);
            end else begin
                want = pending_pixels.pop_front();
                if (m_axis_tdata[7:0] !== want.red || m_axis_tdata[15:8] !== want.green ||
                    m_axis_tdata[23:16] !== want.blue || m_axis_tlast !== want.frame_end) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: rgb exp %h %h %h last %b, got %h %h %h last %b",
                                 want.red, want.green, want.blue, want.frame_end,
                                 m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                                 m_axis_tlast);
                end
            end
        end
    end

    initial begin
        foreach (row_mem[i]) row_mem[i] = '0;
        foreach (win[r, c]) win[r][c] = '0;
        clear_position();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random_frames();
        test_extreme_sizes();
        wait_idle();
        if (pending_pixels.size() != 0) errors++;
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
src/ymf_pkg.sv
src/ymf_line_store.sv
src/ymf_median.sv
src/ycbcr_median_filter_3x3.sv
sim/tb_ycbcr_median_filter_3x3.sv
